@@ rtl/rpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types and constants of the repetition penalty engine.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int VOCAB_SIZE = 65536;
  localparam int ADDR_W     = $clog2(VOCAB_SIZE);
  localparam int INDEX_W    = 16;
  localparam int LOGIT_W    = 32;
  localparam int WEIGHT_W   = 16;
  localparam int INV_W      = 13;
  localparam int ENTRY_W    = LOGIT_W + 1;
  localparam int PROD_W     = LOGIT_W + WEIGHT_W + 1;
  localparam int FRAC_W     = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = WEIGHT_W;

  localparam logic [WEIGHT_W-1:0] PENALTY_RESET = WEIGHT_W'(4096);
  localparam logic [INV_W-1:0]    INVERSE_RESET = INV_W'(4096);

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_PENALIZE = 2'd1,
    OP_READ     = 2'd2,
    OP_NOP      = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PENALTY = 1'b0,
    CFG_INVERSE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_WB
  } state_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] penalty_weight;
    logic [INV_W-1:0]    inverse_weight;
  } cfg_t;

endpackage

@@ rtl/rpe_if.sv @@
// ----------------------------------------------------------------------------
// rpe_in_if / rpe_out_if
// Valid/ready channels for command items and read results.
// ----------------------------------------------------------------------------
interface rpe_in_if import rpe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [INDEX_W-1:0]         token_index;
  logic signed [LOGIT_W-1:0]  logit_value;

  modport source (output valid, output opcode, output token_index, output logit_value,
                  input ready);
  modport sink   (input valid, input opcode, input token_index, input logit_value,
                  output ready);
endinterface

interface rpe_out_if import rpe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [LOGIT_W-1:0]  result_logit;
  logic [INDEX_W-1:0]         result_index;

  modport source (output valid, output result_logit, output result_index, input ready);
  modport sink   (input valid, input result_logit, input result_index, output ready);
endinterface

@@ rtl/rpe_ram.sv @@
// ----------------------------------------------------------------------------
// rpe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rpe_scale.sv @@
// ----------------------------------------------------------------------------
// rpe_scale
// Multiplies a logit by its weight (penalty Q4.12, inverse Q1.12), then rounds and saturates.
// ----------------------------------------------------------------------------
module rpe_scale import rpe_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [LOGIT_W-1:0] logit_i,
  input  cfg_t                      cfg_i,
  output logic signed [LOGIT_W-1:0] result_o
);

  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W-LOGIT_W+1){1'b0}}, {(LOGIT_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1 << (FRAC_W - 1));

  logic signed [WEIGHT_W:0]  weight;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [PROD_W-1:0]  shifted;

  always_comb begin
    if (logit_i > 0) begin
      weight = signed'({1'b0, {(WEIGHT_W-INV_W){1'b0}}, cfg_i.inverse_weight});
    end else begin
      weight = signed'({1'b0, cfg_i.penalty_weight});
    end
  end

  assign prod_d = logit_i * weight;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign rounded = prod_q + HALF;
  assign shifted = rounded >>> FRAC_W;

  always_comb begin
    if (shifted > SAT_HI) begin
      result_o = SAT_HI[LOGIT_W-1:0];
    end else if (shifted < SAT_LO) begin
      result_o = SAT_LO[LOGIT_W-1:0];
    end else begin
      result_o = shifted[LOGIT_W-1:0];
    end
  end

endmodule

@@ rtl/repetition_penalty_engine_top.sv @@
// ----------------------------------------------------------------------------
// repetition_penalty_engine_top
// Logit store with a one-shot repetition penalty per vocabulary entry.
// ----------------------------------------------------------------------------
// Command items arrive on in_i (load, penalize, read, no operation). Each
// store entry holds a logit and its penalized mark in one RAM word.
// A load writes the entry directly. A read goes through a RAM read, then a
// transfer into the output register. A penalize goes through a read, a
// multiply, and a round and write back, or ends after the read when the
// entry is already marked or out of range. The single RAM port pair sets
// this order; one item is in flight at a time.
// A read result waits in the output register on out_o; while it is stalled
// the block keeps accepting loads and penalizes, and a following read holds
// in its data cycle until the register frees.
// Reset sets both weights to 4096 and empties the output register. There is
// no clearing pass: the mark lives with the logit, and a load clears it.
// Configuration writes on cfg_*_i take effect at the next clock edge.
// ----------------------------------------------------------------------------
module repetition_penalty_engine_top import rpe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rpe_in_if.sink                in_i,
  rpe_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t                       cfg_q;
  state_e                     st_q, st_d;
  opcode_e                    op_q;
  logic [INDEX_W-1:0]         idx_q;
  logic                       in_range_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [LOGIT_W-1:0]  out_logit_q;
  logic [INDEX_W-1:0]         out_index_q;
  logic                       out_load;

  logic                       in_accept;
  opcode_e                    in_op;
  logic                       in_range;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [ENTRY_W-1:0]         ram_wdata;
  logic                       ram_re;
  logic [ENTRY_W-1:0]         ram_rdata;
  logic signed [LOGIT_W-1:0]  scaled;

  assign in_op     = opcode_e'(in_i.opcode);
  assign in_range  = 32'(in_i.token_index) < VOCAB_SIZE;
  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.penalty_weight <= PENALTY_RESET;
      cfg_q.inverse_weight <= INVERSE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PENALTY: cfg_q.penalty_weight <= cfg_wdata_i;
        CFG_INVERSE: cfg_q.inverse_weight <= cfg_wdata_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  rpe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (VOCAB_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_i.token_index[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  rpe_scale u_scale (
    .clk_i    (clk_i),
    .logit_i  (ram_rdata[LOGIT_W-1:0]),
    .cfg_i    (cfg_q),
    .result_o (scaled)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= in_op;
      idx_q      <= in_i.token_index;
      in_range_q <= in_range;
    end
    if (out_load) begin
      out_logit_q <= in_range_q ? ram_rdata[LOGIT_W-1:0] : '0;
      out_index_q <= idx_q;
    end
  end

  always_comb begin
    st_d        = st_q;
    in_i.ready  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = in_i.token_index[ADDR_W-1:0];
    ram_wdata   = {1'b0, in_i.logit_value};
    ram_re      = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (st_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          unique case (in_op)
            OP_LOAD:     ram_we = in_range;
            OP_PENALIZE: begin
              ram_re = 1'b1;
              st_d   = ST_DATA;
            end
            OP_READ: begin
              ram_re = 1'b1;
              st_d   = ST_DATA;
            end
            default: ;
          endcase
        end
      end
      ST_DATA: begin
        if (op_q == OP_READ) begin
          if (!out_valid_q || out_o.ready) begin
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            st_d        = ST_IDLE;
          end
        end else if (in_range_q && !ram_rdata[LOGIT_W]) begin
          st_d = ST_WB;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_WB: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[ADDR_W-1:0];
        ram_wdata = {1'b1, scaled};
        st_d      = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_logit = out_logit_q;
  assign out_o.result_index = out_index_q;

`ifndef ASSERT_OFF
  a_read_goes_to_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_op == OP_READ || in_op == OP_PENALIZE) |=> st_q == ST_DATA)
    else $error("read or penalize did not enter the data cycle");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == ST_DATA && op_q == OP_READ))
    else $error("result appeared without a read");

  a_writeback_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_WB |-> ram_we && ram_wdata[LOGIT_W] && $past(op_q == OP_PENALIZE))
    else $error("write back without penalize mark");
`endif

endmodule
